// File: rtl/rrle_pkg.sv
// Package for the record run-length encoder.
// Holds the record constants and the result struct shared by the core and the top level.
// No dependencies.
package rrle_pkg;

    localparam int unsigned RecW   = 48;
    localparam int unsigned CountW = 16;

    // Signature record: 89 5A 50 49 46 0A.
    localparam logic [RecW-1:0] SigRecord  = 48'h895A_5049_460A;
    // End-of-header marker record.
    localparam logic [RecW-1:0] MarkRecord = 48'h0000_FFFF_FFFF;
    localparam logic [RecW-1:0] ZeroRecord = '0;
    localparam logic [CountW-1:0] MaxRun   = 16'hFFFF;

    // Results caused by one input item. The second result, when present,
    // is always the all-zero terminator marked last.
    typedef struct packed {
        logic            emit;
        logic [RecW-1:0] rec;
        logic            last;
        logic            emit_term;
    } result_t;

endpackage

// File: rtl/record_run_length_encoder.sv
// Record run-length encoder, top level.
// A result is registered and appears on m_ in the cycle after the input transfer causing it.
// Throughput: one input transfer per cycle while the output is taken and no terminator
// is pending; the terminator that follows a flushed run or marker takes its own slot in the
// single output register. Reset (aresetn low, synchronous) returns to expecting the
// signature and empties the output register.
module record_run_length_encoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [47:0]               s_tdata,   // [47:0] record
    input  logic                      s_tuser,   // [0] end_of_input
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,   // [47:0] out_record
    output logic                      m_tlast
);

    logic                          accept;
    logic                          out_free;
    rrle_pkg::result_t             res;
    logic                          valid_reg;
    logic [rrle_pkg::RecW-1:0]     data_reg;
    logic                          last_reg;
    logic                          term_reg;

    // The output register can take a new result when empty or being drained.
    assign out_free = !valid_reg || m_tready;
    assign s_tready = out_free && !term_reg;
    assign accept   = s_tvalid && s_tready;

    rrle_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rec     (s_tdata),
        .end_in  (s_tuser),
        .res     (res)
    );

    // Output register with a pending terminator flag behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            term_reg  <= 1'b0;
        end else if (term_reg && m_tready) begin
            valid_reg <= 1'b1;
            last_reg  <= 1'b1;
            term_reg  <= 1'b0;
        end else if (accept) begin
            valid_reg <= res.emit;
            last_reg  <= res.last;
            term_reg  <= res.emit_term;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload follows the same selection; no reset needed.
    always_ff @(posedge aclk) begin
        if (term_reg && m_tready) begin
            data_reg <= rrle_pkg::ZeroRecord;
        end else if (accept) begin
            data_reg <= res.rec;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// File: rtl/rrle_core.sv
// Encoder core: phase, pending run record and run count.
// Produces the results of each accepted item in the same cycle.
// Depends on rrle_pkg.
module rrle_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic [rrle_pkg::RecW-1:0]          rec,
    input  logic                               end_in,
    output rrle_pkg::result_t                  res
);

    typedef enum logic [2:0] {
        PH_SIG   = 3'd0,
        PH_HDR   = 3'd1,
        PH_FIRST = 3'd2,
        PH_RUN   = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [rrle_pkg::RecW-1:0]       run_record_reg, run_record_next;
    logic [rrle_pkg::CountW-1:0]     run_count_reg, run_count_next;
    logic [rrle_pkg::RecW-1:0]       run_word;

    // Word emitted for the pending run; a count above one replaces the top 16 bits.
    always_comb begin
        if (run_count_reg > rrle_pkg::CountW'(1)) begin
            run_word = {run_count_reg, run_record_reg[31:0]};
        end else begin
            run_word = run_record_reg;
        end
    end

    // Next state and results for one item.
    always_comb begin
        phase_next      = phase_reg;
        run_record_next = run_record_reg;
        run_count_next  = run_count_reg;
        res             = '0;
        case (phase_reg)
            PH_SIG: begin
                if (!end_in && rec == rrle_pkg::SigRecord) begin
                    res.emit   = 1'b1;
                    res.rec    = rec;
                    phase_next = PH_HDR;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_HDR: begin
                if (end_in) begin
                    res.emit      = 1'b1;
                    res.rec       = rrle_pkg::MarkRecord;
                    res.emit_term = 1'b1;
                    phase_next    = PH_DONE;
                end else begin
                    res.emit = 1'b1;
                    res.rec  = rec;
                    if (rec == rrle_pkg::MarkRecord) begin
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_FIRST: begin
                if (end_in) begin
                    res.emit   = 1'b1;
                    res.rec    = rrle_pkg::ZeroRecord;
                    res.last   = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    run_record_next = rec;
                    run_count_next  = rrle_pkg::CountW'(1);
                    phase_next      = PH_RUN;
                end
            end
            PH_RUN: begin
                if (end_in || rec == rrle_pkg::ZeroRecord) begin
                    res.emit      = 1'b1;
                    res.rec       = run_word;
                    res.emit_term = 1'b1;
                    phase_next    = PH_DONE;
                end else if (rec == run_record_reg && run_count_reg != rrle_pkg::MaxRun) begin
                    run_count_next = run_count_reg + rrle_pkg::CountW'(1);
                end else begin
                    res.emit        = 1'b1;
                    res.rec         = run_word;
                    run_record_next = rec;
                    run_count_next  = rrle_pkg::CountW'(1);
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // State registers, updated only on an accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIG;
            run_record_reg <= '0;
            run_count_reg  <= rrle_pkg::CountW'(1);
        end else if (accept) begin
            phase_reg      <= phase_next;
            run_record_reg <= run_record_next;
            run_count_reg  <= run_count_next;
        end
    end

endmodule
